[rtl/detection_box_iou_suppress_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the detection box suppression block
// ----------------------------------------------------------------------------
`ifndef DETECTION_BOX_IOU_SUPPRESS_MACROS_SVH
`define DETECTION_BOX_IOU_SUPPRESS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBIS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dbis check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DBIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dbis check failed");

`endif

[rtl/dbis_pkg.sv]
// ----------------------------------------------------------------------------
// dbis_pkg
// Types, constants and helper functions of the box suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbis_pkg;

  localparam logic [15:0] ThrReset = 16'd29491;

  typedef struct packed {
    logic        [9:0]  cls;
    logic        [15:0] score;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } dbis_entry_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dbis_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_WRITE,
    ST_SEL,
    ST_SEND
  } dbis_state_e;

  // Exact 17-bit signed difference a - b.
  function automatic logic signed [16:0] sub17(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    return $signed({a[15], a}) - $signed({b[15], b});
  endfunction

  // Raise to lo, then cap at hi (hi wins when lo > hi).
  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    logic signed [15:0] r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [33:0] v);
    return $signed({{2{v[33]}}, v});
  endfunction

endpackage

`default_nettype wire

[rtl/dbis_mem.sv]
// ----------------------------------------------------------------------------
// dbis_mem
// Kept-box table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbis_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [AddrW-1:0]          waddr_i,
  input  dbis_pkg::dbis_entry_t     wdata_i,
  input  wire                       re_i,
  input  wire  [AddrW-1:0]          raddr_i,
  output dbis_pkg::dbis_entry_t     rdata_o
);
  import dbis_pkg::*;

  dbis_entry_t mem_q [Depth];
  dbis_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/dbis_iou.sv]
// ----------------------------------------------------------------------------
// dbis_iou
// Four-stage overlap test of the candidate against one stored entry a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbis_iou #(
  parameter int IdxW = 6
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       flush_i,
  input  wire                       prep_i,
  input  wire  [15:0]               thr_i,
  input  dbis_pkg::dbis_entry_t     cand_i,
  input  wire                       in_valid_i,
  input  wire  [IdxW-1:0]           in_slot_i,
  input  dbis_pkg::dbis_entry_t     entry_i,
  output dbis_pkg::dbis_res_t       res_o,
  output logic [IdxW-1:0]           res_slot_o,
  output logic [15:0]               res_score_o
);
  import dbis_pkg::*;

  logic signed [33:0] area_a_q;
  logic [3:0]         v_q;
  logic [IdxW-1:0]    slot0_q, slot1_q, slot2_q, slot3_q;
  logic [15:0]        score0_q, score1_q, score2_q, score3_q;
  logic               match0_q, match1_q, match2_q, match3_q;
  logic signed [16:0] bw0_q, bh0_q, iw0_q, ih0_q;
  logic signed [33:0] area_b1_q, inter1_q, inter2_q, inter3_q;
  logic signed [35:0] uni2_q;
  logic signed [52:0] prod3_q;
  logic               pos3_q;
  logic signed [52:0] lhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (flush_i) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (prep_i) begin
      area_a_q <= sub17(cand_i.right, cand_i.left) * sub17(cand_i.bottom, cand_i.top);
    end
    // stage 0: spans and clamped intersection edges
    slot0_q  <= in_slot_i;
    score0_q <= entry_i.score;
    match0_q <= (entry_i.cls == cand_i.cls);
    bw0_q    <= sub17(entry_i.right, entry_i.left);
    bh0_q    <= sub17(entry_i.bottom, entry_i.top);
    iw0_q    <= sub17(clamp16(cand_i.right, entry_i.left, entry_i.right),
                      clamp16(cand_i.left, entry_i.left, entry_i.right));
    ih0_q    <= sub17(clamp16(cand_i.bottom, entry_i.top, entry_i.bottom),
                      clamp16(cand_i.top, entry_i.top, entry_i.bottom));
    // stage 1: areas
    slot1_q   <= slot0_q;
    score1_q  <= score0_q;
    match1_q  <= match0_q;
    area_b1_q <= bw0_q * bh0_q;
    inter1_q  <= iw0_q * ih0_q;
    // stage 2: union
    slot2_q  <= slot1_q;
    score2_q <= score1_q;
    match2_q <= match1_q;
    uni2_q   <= sx36(area_a_q) + sx36(area_b1_q) - sx36(inter1_q);
    inter2_q <= inter1_q;
    // stage 3: threshold times union
    slot3_q  <= slot2_q;
    score3_q <= score2_q;
    match3_q <= match2_q;
    prod3_q  <= $signed({1'b0, thr_i}) * uni2_q;
    pos3_q   <= (uni2_q > 36'sd0);
    inter3_q <= inter2_q;
  end

  assign lhs         = $signed({{3{inter3_q[33]}}, inter3_q, 16'b0});
  assign res_o.valid = v_q[3];
  assign res_o.hit   = match3_q && pos3_q && (lhs >= prod3_q);
  assign res_slot_o  = slot3_q;
  assign res_score_o = score3_q;

endmodule

`default_nettype wire

[rtl/detection_box_iou_suppress.sv]
// Per candidate: an accept step, a prep step, one read per stored entry
// scanned, the overlap pipeline drain and a write step.
// End of frame: each result costs one pass over the n kept entries through
// the single read port of the kept-box memory.
// Reset (async, active low) clears the count, the overflow flag and the state
// machine and loads the threshold 29491; table contents are not cleared.
// ----------------------------------------------------------------------------
// detection_box_iou_suppress
// Greedy per-class suppression of detection boxes over a memory-held table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module detection_box_iou_suppress #(
  parameter int MAX_KEPT = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [15:0]       cfg_data_i,
  input  wire               cand_valid_i,
  output logic              cand_ready_o,
  input  wire  [9:0]        class_id_i,
  input  wire  [15:0]       score_i,
  input  wire signed [15:0] box_left_i,
  input  wire signed [15:0] box_top_i,
  input  wire signed [15:0] box_right_i,
  input  wire signed [15:0] box_bottom_i,
  input  wire               last_i,
  output logic              res_valid_o,
  input  wire               res_ready_i,
  output logic [9:0]        out_class_o,
  output logic [15:0]       out_score_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_top_o,
  output logic signed [15:0] out_right_o,
  output logic signed [15:0] out_bottom_o,
  output logic              out_valid_o,
  output logic              out_overflow_o,
  output logic              out_last_o
);
  import dbis_pkg::*;

  localparam int IdxW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CntW = $clog2(MAX_KEPT + 1);

  dbis_state_e state_q, state_d;

  // control state
  logic [15:0]     thr_q;
  logic [CntW-1:0] kept_cnt_q;
  logic            ovf_q;
  logic [CntW-1:0] iss_q;
  logic            rd_v_q;
  logic [IdxW-1:0] rd_slot_q;
  logic            mhit_q;
  logic            prev_v_q;
  logic            best_v_q;
  logic [CntW-1:0] out_cnt_q;

  // payload
  dbis_entry_t     cand_q;
  logic            cand_last_q;
  logic [IdxW-1:0] mslot_q;
  logic [15:0]     mscore_q;
  logic [15:0]     prev_s_q;
  logic [IdxW-1:0] prev_j_q;
  logic [15:0]     best_s_q;
  logic [IdxW-1:0] best_j_q;
  dbis_entry_t     best_e_q;
  dbis_entry_t     res_e_q;
  logic            res_last_q;

  // datapath wiring
  dbis_entry_t     rdata;
  dbis_res_t       res;
  logic [IdxW-1:0] res_slot;
  logic [15:0]     res_score;
  logic [IdxW-1:0] last_idx;
  logic            issue, hit_now, scan_end, sel_end;
  logic            elig, take;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic            room;
  dbis_entry_t     pick_e;
  logic [IdxW-1:0] pick_j;

  assign last_idx = IdxW'(kept_cnt_q - 1'b1);
  assign room     = (kept_cnt_q < CntW'(MAX_KEPT));

  // Advance the read pointer while entries remain; stop on the first merge hit.
  assign hit_now  = (state_q == ST_SCAN) && res.valid && res.hit;
  assign scan_end = (state_q == ST_SCAN) && res.valid && !res.hit && (res_slot == last_idx);
  assign issue    = ((state_q == ST_SCAN) || (state_q == ST_SEL)) &&
                    (iss_q < kept_cnt_q) && !hit_now;
  assign sel_end  = (state_q == ST_SEL) && rd_v_q && (rd_slot_q == last_idx);

  // Selection order: descending score, lower slot first on ties. An entry is
  // still pending when it ranks after the previously emitted one.
  assign elig = !prev_v_q || (rdata.score < prev_s_q) ||
                ((rdata.score == prev_s_q) && (rd_slot_q > prev_j_q));
  assign take = (state_q == ST_SEL) && rd_v_q && elig &&
                (!best_v_q || (rdata.score > best_s_q));
  assign pick_e = take ? rdata : best_e_q;
  assign pick_j = take ? rd_slot_q : best_j_q;

  // Replace a merged entry on a strictly higher score; without a merge, append while there is room.
  assign mem_we    = (state_q == ST_WRITE) &&
                     (mhit_q ? (cand_q.score > mscore_q) : room);
  assign mem_waddr = mhit_q ? mslot_q : kept_cnt_q[IdxW-1:0];

  dbis_mem #(
    .Depth (MAX_KEPT),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cand_q),
    .re_i    (issue),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  dbis_iou #(
    .IdxW (IdxW)
  ) u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (hit_now),
    .prep_i      (state_q == ST_PREP),
    .thr_i       (thr_q),
    .cand_i      (cand_q),
    .in_valid_i  (rd_v_q && (state_q == ST_SCAN)),
    .in_slot_i   (rd_slot_q),
    .entry_i     (rdata),
    .res_o       (res),
    .res_slot_o  (res_slot),
    .res_score_o (res_score)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cand_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = (kept_cnt_q == '0) ? ST_WRITE : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit_now || scan_end) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = cand_last_q ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        if (sel_end) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (res_ready_i) state_d = res_last_q ? ST_IDLE : ST_SEL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThrReset;
      kept_cnt_q <= '0;
      ovf_q      <= 1'b0;
      iss_q      <= '0;
      rd_v_q     <= 1'b0;
      mhit_q     <= 1'b0;
      prev_v_q   <= 1'b0;
      best_v_q   <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      // drop reads still in flight once a merge hit is found
      rd_v_q <= issue && !hit_now;
      if (issue) iss_q <= iss_q + 1'b1;
      case (state_q)
        ST_IDLE: begin
          iss_q  <= '0;
          mhit_q <= 1'b0;
        end
        ST_SCAN: begin
          if (hit_now) mhit_q <= 1'b1;
        end
        ST_WRITE: begin
          if (!mhit_q) begin
            if (room) kept_cnt_q <= kept_cnt_q + 1'b1;
            else      ovf_q      <= 1'b1;
          end
          iss_q     <= '0;
          prev_v_q  <= 1'b0;
          best_v_q  <= 1'b0;
          out_cnt_q <= '0;
        end
        ST_SEL: begin
          if (sel_end) begin
            prev_v_q <= 1'b1;
            best_v_q <= 1'b0;
          end else if (take) begin
            best_v_q <= 1'b1;
          end
        end
        ST_SEND: begin
          if (res_ready_i) begin
            out_cnt_q <= out_cnt_q + 1'b1;
            iss_q     <= '0;
            if (res_last_q) begin
              kept_cnt_q <= '0;
              ovf_q      <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_slot_q <= iss_q[IdxW-1:0];
    if (cand_valid_i && cand_ready_o) begin
      cand_q.cls    <= class_id_i;
      cand_q.score  <= score_i;
      cand_q.left   <= box_left_i;
      cand_q.top    <= box_top_i;
      cand_q.right  <= box_right_i;
      cand_q.bottom <= box_bottom_i;
      cand_last_q   <= last_i;
    end
    if (hit_now) begin
      mslot_q  <= res_slot;
      mscore_q <= res_score;
    end
    if (take) begin
      best_s_q <= rdata.score;
      best_j_q <= rd_slot_q;
      best_e_q <= rdata;
    end
    if (sel_end) begin
      res_e_q    <= pick_e;
      res_last_q <= (CntW'(out_cnt_q + 1'b1) == kept_cnt_q);
      prev_s_q   <= pick_e.score;
      prev_j_q   <= pick_j;
    end
  end

  assign cand_ready_o   = (state_q == ST_IDLE);
  assign res_valid_o    = (state_q == ST_SEND);
  assign out_class_o    = res_e_q.cls;
  assign out_score_o    = res_e_q.score;
  assign out_left_o     = res_e_q.left;
  assign out_top_o      = res_e_q.top;
  assign out_right_o    = res_e_q.right;
  assign out_bottom_o   = res_e_q.bottom;
  assign out_valid_o    = 1'b1;
  assign out_overflow_o = ovf_q;
  assign out_last_o     = res_last_q;

endmodule

`default_nettype wire

[rtl/dbis_check.sv]
// ----------------------------------------------------------------------------
// dbis_check
// Port-level checks of the box suppression block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "detection_box_iou_suppress_macros.svh"

module dbis_check (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cand_valid_i,
  input wire        cand_ready_o,
  input wire        res_valid_o,
  input wire        res_ready_i,
  input wire [15:0] out_score_o,
  input wire        out_valid_o,
  input wire        out_last_o
);

  // One item in flight: never take a candidate while a result waits.
  `DBIS_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, res_valid_o, !cand_ready_o)

  // A stalled result holds its score.
  `DBIS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o && $stable(out_score_o))

  // A frame with a candidate always keeps at least one box.
  `DBIS_ASSERT_SAME(a_kept_valid, clk_i, rst_ni, res_valid_o, out_valid_o)

  // After the frame's last result the block takes candidates again.
  `DBIS_ASSERT_NEXT(a_frame_done, clk_i, rst_ni, res_valid_o && res_ready_i && out_last_o, cand_ready_o)

endmodule

bind detection_box_iou_suppress dbis_check u_dbis_check (.*);

`default_nettype wire

[tb/detection_box_iou_suppress_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_iou_suppress_tb
// Self-checking regression of the greedy per-class box suppression block:
// frames of candidate boxes go in under several overlap thresholds, and a
// scoreboard predicts the kept boxes of each frame in score order and checks
// every emitted result field by field.
// ----------------------------------------------------------------------------

typedef struct {
  logic [9:0]         cls;
  logic [15:0]        score;
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] right;
  logic signed [15:0] bottom;
  logic               last;
} box_item_t;

typedef struct {
  logic [9:0]         cls;
  logic [15:0]        score;
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] right;
  logic signed [15:0] bottom;
  logic               valid;
  logic               overflow;
  logic               last;
} kept_box_t;

class suppress_scoreboard;
  localparam int Depth = 64;
  box_item_t   table_q[Depth];
  int          kept_n;
  bit          ovf;
  logic [15:0] thr;
  kept_box_t   kept_boxes_q[$];
  int          errors;
  int          n_cand;
  int          n_res;
  int          n_merge;
  int          n_drop;

  function void clear_state();
    thr    = 16'd29491;
    kept_n = 0;
    ovf    = 0;
  endfunction

  function bit boxes_overlap(box_item_t a, box_item_t b);
    longint area_a, area_b, il, it, ir, ib, inter, uni;
    area_a = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top));
    area_b = (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top));
    il = clamp(a.left, b.left, b.right);
    it = clamp(a.top, b.top, b.bottom);
    ir = clamp(a.right, b.left, b.right);
    ib = clamp(a.bottom, b.top, b.bottom);
    inter = (ir - il) * (ib - it);
    uni = area_a + area_b - inter;
    if (uni <= 0) return 0;
    return inter * 65536 >= longint'({48'd0, thr}) * uni;
  endfunction

  // Raise to lo, then cap at hi.
  function longint clamp(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function void note_candidate(box_item_t c);
    bit        merged;
    bit        used[Depth];
    int        best;
    kept_box_t r;
    merged = 0;
    n_cand++;
    for (int j = 0; j < kept_n; j++) begin
      if (table_q[j].cls == c.cls && boxes_overlap(c, table_q[j])) begin
        if (c.score > table_q[j].score) table_q[j] = c;
        merged = 1;
        n_merge++;
        break;
      end
    end
    if (!merged) begin
      if (kept_n < Depth) begin
        table_q[kept_n] = c;
        kept_n++;
      end else begin
        ovf = 1;
        n_drop++;
      end
    end
    if (!c.last) return;
    if (kept_n == 0) begin
      r = '{default: 0};
      r.overflow = ovf;
      r.last = 1;
      kept_boxes_q.push_back(r);
    end
    foreach (used[j]) used[j] = 0;
    // Emit by descending score, lower slot first on a tie.
    for (int k = 0; k < kept_n; k++) begin
      best = -1;
      for (int j = 0; j < kept_n; j++)
        if (!used[j] && (best < 0 || table_q[j].score > table_q[best].score)) best = j;
      used[best] = 1;
      r.cls      = table_q[best].cls;
      r.score    = table_q[best].score;
      r.left     = table_q[best].left;
      r.top      = table_q[best].top;
      r.right    = table_q[best].right;
      r.bottom   = table_q[best].bottom;
      r.valid    = 1;
      r.overflow = ovf;
      r.last     = (k == kept_n - 1);
      kept_boxes_q.push_back(r);
    end
    kept_n = 0;
    ovf    = 0;
  endfunction

  function void check_result(kept_box_t got);
    kept_box_t exp_box;
    n_res++;
    if (kept_boxes_q.size() == 0) begin
      $error("unexpected result: class %0d score %0d", got.cls, got.score);
      errors++;
      return;
    end
    exp_box = kept_boxes_q.pop_front();
    if (got.cls !== exp_box.cls) begin
      $error("out_class: expected %0d, got %0d", exp_box.cls, got.cls); errors++;
    end
    if (got.score !== exp_box.score) begin
      $error("out_score: expected %0d, got %0d", exp_box.score, got.score); errors++;
    end
    if (got.left !== exp_box.left) begin
      $error("out_left: expected %0d, got %0d", exp_box.left, got.left); errors++;
    end
    if (got.top !== exp_box.top) begin
      $error("out_top: expected %0d, got %0d", exp_box.top, got.top); errors++;
    end
    if (got.right !== exp_box.right) begin
      $error("out_right: expected %0d, got %0d", exp_box.right, got.right); errors++;
    end
    if (got.bottom !== exp_box.bottom) begin
      $error("out_bottom: expected %0d, got %0d", exp_box.bottom, got.bottom); errors++;
    end
    if (got.valid !== exp_box.valid) begin
      $error("out_valid: expected %0d, got %0d", exp_box.valid, got.valid); errors++;
    end
    if (got.overflow !== exp_box.overflow) begin
      $error("out_overflow: expected %0d, got %0d", exp_box.overflow, got.overflow); errors++;
    end
    if (got.last !== exp_box.last) begin
      $error("out_last: expected %0d, got %0d", exp_box.last, got.last); errors++;
    end
  endfunction
endclass

module detection_box_iou_suppress_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;
  logic               cand_valid_i = 1'b0;
  logic               cand_ready_o;
  logic [9:0]         class_id_i = '0;
  logic [15:0]        score_i = '0;
  logic signed [15:0] box_left_i = '0;
  logic signed [15:0] box_top_i = '0;
  logic signed [15:0] box_right_i = '0;
  logic signed [15:0] box_bottom_i = '0;
  logic               last_i = 1'b0;
  logic               res_valid_o;
  logic               res_ready_i = 1'b0;
  logic [9:0]         out_class_o;
  logic [15:0]        out_score_o;
  logic signed [15:0] out_left_o;
  logic signed [15:0] out_top_o;
  logic signed [15:0] out_right_o;
  logic signed [15:0] out_bottom_o;
  logic               out_valid_o;
  logic               out_overflow_o;
  logic               out_last_o;

  suppress_scoreboard sb;
  bit                 hold_results = 0;  // request one long receiver stall
  bit                 stim_done = 0;
  box_item_t          anchors[4];        // well-formed cluster centers of a frame
  int                 n_frames = 0;

  always #5 clk_i = ~clk_i;

  detection_box_iou_suppress u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .cand_valid_i   (cand_valid_i),
    .cand_ready_o   (cand_ready_o),
    .class_id_i     (class_id_i),
    .score_i        (score_i),
    .box_left_i     (box_left_i),
    .box_top_i      (box_top_i),
    .box_right_i    (box_right_i),
    .box_bottom_i   (box_bottom_i),
    .last_i         (last_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_class_o    (out_class_o),
    .out_score_o    (out_score_o),
    .out_left_o     (out_left_o),
    .out_top_o      (out_top_o),
    .out_right_o    (out_right_o),
    .out_bottom_o   (out_bottom_o),
    .out_valid_o    (out_valid_o),
    .out_overflow_o (out_overflow_o),
    .out_last_o     (out_last_o)
  );

  // Offer one candidate after a random gap and hold it until accepted.
  // Called at a rising edge; returns at the edge that took the item.
  task automatic send_box(box_item_t c, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      cand_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cand_valid_i <= 1'b1;
    class_id_i   <= c.cls;
    score_i      <= c.score;
    box_left_i   <= c.left;
    box_top_i    <= c.top;
    box_right_i  <= c.right;
    box_bottom_i <= c.bottom;
    last_i       <= c.last;
    // Sample the handshake mid-cycle, where both sides are settled.
    do @(negedge clk_i); while (!cand_ready_o);
    @(posedge clk_i);
    sb.note_candidate(c);
    if (c.last) n_frames++;
  endtask

  function automatic box_item_t make_box(int cls, int sc, int l, int t, int r, int b, bit lst);
    box_item_t c;
    c.cls = 10'(cls); c.score = 16'(sc); c.left = 16'(l); c.top = 16'(t);
    c.right = 16'(r); c.bottom = 16'(b);
    c.last = lst;
    return c;
  endfunction

  // Random candidate: mostly jittered copies of the frame's anchors so that
  // merges and replacements happen; the rest is raw noise and odd shapes.
  function automatic box_item_t rand_box(bit lst);
    box_item_t c;
    int        k, j, w;
    int        mode;
    mode = $urandom_range(0, 9);
    k = $urandom_range(0, 3);
    j = $urandom_range(0, 2) == 0 ? 200 : 24;
    c = anchors[k];
    c.left   = 16'(int'(anchors[k].left) + int'($urandom_range(0, 2 * j)) - j);
    c.top    = 16'(int'(anchors[k].top) + int'($urandom_range(0, 2 * j)) - j);
    c.right  = 16'(int'(anchors[k].right) + int'($urandom_range(0, 2 * j)) - j);
    c.bottom = 16'(int'(anchors[k].bottom) + int'($urandom_range(0, 2 * j)) - j);
    c.score  = $urandom_range(0, 3) == 0 ? 16'(1000 * $urandom_range(0, 3))
                                         : 16'($urandom);
    if (mode == 7) begin
      c.cls = 10'($urandom); c.left = 16'($urandom); c.top = 16'($urandom);
      c.right = 16'($urandom); c.bottom = 16'($urandom);
    end else if (mode == 8) begin
      // swap edges for an inverted box
      w = int'(c.left); c.left = c.right; c.right = 16'(w);
    end else if (mode == 9) begin
      c.right = c.left;  // zero width
    end
    c.last = lst;
    return c;
  endfunction

  task automatic new_anchors();
    int x, y;
    foreach (anchors[k]) begin
      x = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 60000)) - 30000
                                    : int'($urandom_range(0, 4000)) - 2000;
      y = int'($urandom_range(0, 8000)) - 4000;
      anchors[k].cls    = $urandom_range(0, 2) == 0 ? 10'($urandom) : 10'($urandom_range(0, 3));
      anchors[k].left   = 16'(x);
      anchors[k].top    = 16'(y);
      anchors[k].right  = 16'(x + int'($urandom_range(16, 1600)));
      anchors[k].bottom = 16'(y + int'($urandom_range(16, 1600)));
    end
  endtask

  // Wait until every predicted result is back, then let the block drain.
  task automatic wait_idle();
    while (sb.kept_boxes_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    // withdraw the last offer so the block sees no new item while idle
    cand_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.thr = value;
  endtask

  task automatic run_frames(int n_items);
    int left_n, len;
    left_n = n_items;
    while (left_n > 0) begin
      new_anchors();
      len = $urandom_range(1, 12);
      if (len > left_n) len = left_n;
      for (int i = 0; i < len; i++) send_box(rand_box(i == len - 1));
      left_n -= len;
    end
  endtask

  // Result side: random ready gaps, plus one long hold when asked.
  initial begin
    kept_box_t got;
    int        gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        res_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_results = 0;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        res_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      do @(negedge clk_i); while (!res_valid_o);
      got.cls      = out_class_o;
      got.score    = out_score_o;
      got.left     = out_left_o;
      got.top      = out_top_o;
      got.right    = out_right_o;
      got.bottom   = out_bottom_o;
      got.valid    = out_valid_o;
      got.overflow = out_overflow_o;
      got.last     = out_last_o;
      @(posedge clk_i);
      sb.check_result(got);
    end
  end

  // Stimulus.
  initial begin
    logic [15:0] thresholds[5];
    sb = new();
    sb.clear_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frame one, reset threshold: field extremes, merge with a
    // higher score (replace), lower score (keep old), equal score tie,
    // same box in another class, zero union and inverted boxes.
    send_box(make_box(0, 100, 0, 0, 160, 160, 0));
    send_box(make_box(0, 200, 0, 0, 160, 160, 0));
    send_box(make_box(0, 50, 2, 2, 160, 160, 0));
    send_box(make_box(1023, 200, 0, 0, 160, 160, 0));
    send_box(make_box(5, 65535, -32768, -32768, 32767, 32767, 0));
    send_box(make_box(5, 0, -32768, -32768, 32767, 32767, 0));
    send_box(make_box(6, 0, 10, 10, 10, 10, 0));
    send_box(make_box(6, 7, 10, 10, 10, 10, 0));
    send_box(make_box(7, 300, 500, 500, 100, 100, 0));
    send_box(make_box(7, 301, 500, 500, 100, 100, 0));
    send_box(make_box(8, 200, 32767, 32767, -32768, -32768, 0));
    send_box(make_box(9, 200, 1000, 0, 1160, 160, 1));
    // Directed frame two: a lone box, then a frame of ties.
    send_box(make_box(682, 43690, 21845, -21846, 21846, -21845, 1));
    send_box(make_box(341, 21845, -100, -100, 100, 100, 0));
    send_box(make_box(2, 21845, 300, 300, 400, 400, 0));
    send_box(make_box(3, 21845, -400, 300, -300, 400, 1));

    // Long receiver hold while a busy frame and the next ones keep coming.
    hold_results = 1;
    run_frames(60);

    thresholds = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'($urandom)};
    foreach (thresholds[p]) begin
      write_threshold(thresholds[p]);
      run_frames(60);
    end

    // Table overflow: distinct classes never merge, so the tail is dropped.
    for (int i = 0; i < 70; i++)
      send_box(make_box(i * 14, int'(16'($urandom)), i * 16, 0, i * 16 + 8, 8, i == 69), 1);

    write_threshold(16'd29491);
    run_frames(50);

    cand_valid_i <= 1'b0;
    last_i       <= 1'b0;
    wait_idle();
    $display("covered %0d candidates in %0d frames: %0d merges, %0d drops on a full table",
             sb.n_cand, n_frames, sb.n_merge, sb.n_drop);
    $display("checked %0d kept boxes under six overlap thresholds", sb.n_res);
    if (sb.errors == 0 && sb.kept_boxes_q.size() == 0) begin
      $display("detection_box_iou_suppress regression: pass");
    end else begin
      $display("detection_box_iou_suppress regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("detection_box_iou_suppress regression: fail");
    $finish;
  end

endmodule
